// ===== hw/rtl/attitude_pid_motor_mixer_assert.svh =====
// assertion macros for the attitude controller
`ifndef ATTITUDE_PID_MOTOR_MIXER_ASSERT_SVH
`define ATTITUDE_PID_MOTOR_MIXER_ASSERT_SVH
// property must hold whenever the block is out of reset
`define APM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// property checked also during reset
`define APM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);
`endif

// ===== hw/rtl/apm_pkg.sv =====
// shared types and constants for the attitude controller
package apm_pkg;
    localparam int YAW_STEP_PERIODS_DEF = 100;

    localparam logic [15:0] GAIN_PROP_RST  = 16'd512;
    localparam logic [23:0] GAIN_INTEG_RST = 24'd8389;
    localparam logic [7:0]  MOVE_THR_RST   = 8'd2;
    localparam logic [15:0] HOLD_RST       = 16'd500;
    localparam logic [9:0]  LIMIT_RST      = 10'd150;

    // reciprocals for truncating division, 2^20/25 and 2^24/500 rounded up
    localparam logic [31:0] DIV25_RECIP  = 32'd41944;
    localparam logic [31:0] DIV500_RECIP = 32'd33555;

    // register indexes
    localparam logic [2:0] REG_GAIN_PROP  = 3'd0;
    localparam logic [2:0] REG_GAIN_INTEG = 3'd1;
    localparam logic [2:0] REG_LVL_PITCH  = 3'd2;
    localparam logic [2:0] REG_LVL_ROLL   = 3'd3;
    localparam logic [2:0] REG_LVL_YAW    = 3'd4;
    localparam logic [2:0] REG_MOVE_THR   = 3'd5;
    localparam logic [2:0] REG_HOLD       = 3'd6;
    localparam logic [2:0] REG_LIMIT      = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_CHECK,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_M,
        ST_ACC,
        ST_MIX,
        ST_OUT
    } t_state;

    // multiplier request from sequencer
    typedef struct packed {
        logic signed [40:0] a;
        logic signed [31:0] b;
    } t_mul_req;

    function automatic logic signed [31:0] sat16(input logic signed [31:0] v);
        if (v > 32'sd32767) return 32'sd32767;
        if (v < -32'sd32768) return -32'sd32768;
        return v;
    endfunction

    function automatic logic signed [31:0] abs32(input logic signed [31:0] v);
        return (v < 0) ? -v : v;
    endfunction

    // quotient toward zero by 25, exact for magnitudes up to 32768
    function automatic logic signed [15:0] div25(input logic signed [15:0] v);
        logic [15:0] mag;
        logic [31:0] prod;
        mag = v[15] ? 16'(-v) : 16'(v);
        prod = 32'(mag) * DIV25_RECIP;
        return v[15] ? -16'(prod[31:20]) : 16'(prod[31:20]);
    endfunction

    // quotient toward zero by 500, exact for magnitudes up to 32768
    function automatic logic signed [15:0] div500(input logic signed [15:0] v);
        logic [15:0] mag;
        logic [31:0] prod;
        mag = v[15] ? 16'(-v) : 16'(v);
        prod = 32'(mag) * DIV500_RECIP;
        return v[15] ? -16'(prod[31:24]) : 16'(prod[31:24]);
    endfunction
endpackage

// ===== hw/rtl/apm_mul.sv =====
// shared registered signed multiplier, split into two partial products
module apm_mul (
    input  logic                 i_clk,
    input  apm_pkg::t_mul_req    i_req,
    output logic signed [72:0]   o_prod
);
    // low 20 bits of a unsigned, high part signed
    logic signed [20:0] r_lo;
    logic signed [20:0] r_hi;
    logic signed [31:0] r_b;
    logic signed [52:0] r_plo;
    logic signed [52:0] r_phi;

    // operand split
    always_ff @(posedge i_clk) begin
        r_lo <= $signed({1'b0, i_req.a[19:0]});
        r_hi <= i_req.a[40:20];
        r_b  <= i_req.b;
    end

    // two partial products
    always_ff @(posedge i_clk) begin
        r_plo <= 53'(r_lo) * 53'(r_b);
        r_phi <= 53'(r_hi) * 53'(r_b);
    end

    assign o_prod = 73'(r_plo) + (73'(r_phi) <<< 20);
endmodule

// ===== hw/rtl/attitude_pid_motor_mixer.sv =====
// attitude pi controller with four-motor mixer, top level
// steps: prep, check, then per axis the p, i and weight multiplies and an accumulate;
// then mix and output, skipping to output when no pi update runs; inputs stall until idle
// a new input is taken while the last result waits; the output step holds until it transfers
// reset: synchronous active low; clears state and loads register defaults
module attitude_pid_motor_mixer #(
    parameter int YAW_STEP_PERIODS = apm_pkg::YAW_STEP_PERIODS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_packet_valid,
    input  logic [13:0] i_throttle_raw,
    input  logic [13:0] i_fore_aft_raw,
    input  logic [13:0] i_side_raw,
    input  logic [13:0] i_turn_raw,
    input  logic        i_kill_switch,
    input  logic signed [8:0] i_meas_pitch,
    input  logic signed [8:0] i_meas_roll,
    input  logic signed [8:0] i_meas_yaw,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [13:0] o_cmp_front,
    output logic [13:0] o_cmp_back,
    output logic [13:0] o_cmp_left,
    output logic [13:0] o_cmp_right,
    output logic        o_loop_updated
);
    localparam int TW = $clog2(YAW_STEP_PERIODS + 1);

    apm_pkg::t_state r_state, n_state;

    // configuration
    logic [15:0] r_kp;
    logic [23:0] r_ki;
    logic signed [8:0] r_lvl [3];
    logic [7:0]  r_thr;
    logic [15:0] r_hold;
    logic [9:0]  r_lim;

    // state
    logic signed [15:0] r_tgt [3];
    logic signed [15:0] r_last [3];
    logic signed [15:0] r_sum [3];
    logic [15:0] r_dev;
    logic [TW-1:0] r_tick;
    logic signed [10:0] r_off [4];
    logic signed [12:0] r_base;
    logic signed [15:0] r_stk [3];
    logic r_kill;

    // per item
    logic signed [8:0] r_meas [3];
    logic [1:0]  r_ax;
    logic [1:0]  r_wait;
    logic signed [15:0] r_err;
    logic signed [63:0] r_acc;
    logic signed [40:0] r_m;
    logic signed [31:0] r_u [3];
    logic r_upd;
    logic r_ovalid;

    apm_pkg::t_mul_req w_req;
    logic signed [72:0] w_prod;

    apm_mul u_mul (.i_clk(i_clk), .i_req(w_req), .o_prod(w_prod));

    logic w_in_xfer, w_out_xfer;
    assign w_in_xfer  = i_valid && !o_stall;
    assign w_out_xfer = r_ovalid && !i_stall;
    assign o_stall    = (r_state != apm_pkg::ST_IDLE);
    assign o_valid    = r_ovalid;

    // combinational helpers
    logic signed [31:0] w_tp, w_tr, w_ty, w_e, w_w, w_unw;
    logic signed [15:0] w_yq;
    logic signed [31:0] w_yr, w_yb;
    logic w_off_t, w_moved;
    always_comb begin
        w_tp = 32'(apm_pkg::div25(16'(r_lvl[0]) * 16'sd25 + r_stk[0]));
        w_tr = 32'(apm_pkg::div25(16'(r_lvl[1]) * 16'sd25 + r_stk[1]));
        // yaw nudge: split the stick into quotient and remainder by 500
        w_yq = apm_pkg::div500(r_stk[2]);
        w_yr = 32'(r_stk[2]) - 32'(w_yq) * 32'sd500;
        w_yb = 32'(r_tgt[2]) + 32'(w_yq);
        if (w_yb > 32'sd0 && w_yr < 32'sd0) w_yb = w_yb - 32'sd1;
        else if (w_yb < 32'sd0 && w_yr > 32'sd0) w_yb = w_yb + 32'sd1;
        w_ty = apm_pkg::sat16(w_yb);
        w_off_t = 1'b0;
        w_moved = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (apm_pkg::abs32(32'(r_tgt[i]) - 32'(r_meas[i])) >= 32'(r_thr))
                w_off_t = 1'b1;
            if (apm_pkg::abs32(32'(r_last[i]) - 32'(r_meas[i])) >= 32'(r_thr))
                w_moved = 1'b1;
        end
        w_unw = 32'(r_tgt[2]);
        if (32'(r_tgt[2]) - 32'(r_meas[2]) > 32'sd280) w_unw = w_unw - 32'sd360;
        else if (32'(r_tgt[2]) - 32'(r_meas[2]) < -32'sd280) w_unw = w_unw + 32'sd360;
        w_unw = apm_pkg::sat16(w_unw);
        w_e = apm_pkg::sat16(32'(r_tgt[r_ax]) - 32'(r_meas[r_ax]));
        w_w = 32'sd65536 - 32'sd3277 * 32'(r_err);
    end

    // multiplier operand select
    always_comb begin
        w_req.a = '0;
        w_req.b = '0;
        unique case (r_state)
            apm_pkg::ST_MUL_P: begin
                w_req.a = 41'(r_err);
                w_req.b = 32'($signed({1'b0, r_kp}));
            end
            apm_pkg::ST_MUL_I: begin
                w_req.a = 41'(r_sum[r_ax]);
                w_req.b = $signed({8'd0, r_ki});
            end
            apm_pkg::ST_MUL_M: begin
                w_req.a = r_m;
                w_req.b = w_w;
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            apm_pkg::ST_IDLE:  if (w_in_xfer) n_state = apm_pkg::ST_PREP;
            apm_pkg::ST_PREP:  n_state = apm_pkg::ST_CHECK;
            apm_pkg::ST_CHECK: n_state = (w_moved || (r_dev + 16'(w_off_t && r_dev != 16'hFFFF))
                                          >= r_hold) ? apm_pkg::ST_MUL_P : apm_pkg::ST_OUT;
            apm_pkg::ST_MUL_P: if (r_wait == 2'd3) n_state = apm_pkg::ST_MUL_I;
            apm_pkg::ST_MUL_I: if (r_wait == 2'd3) n_state = apm_pkg::ST_MUL_M;
            apm_pkg::ST_MUL_M: if (r_wait == 2'd3) n_state = apm_pkg::ST_ACC;
            apm_pkg::ST_ACC:   n_state = (r_ax == 2'd2) ? apm_pkg::ST_MIX : apm_pkg::ST_MUL_P;
            apm_pkg::ST_MIX:   n_state = apm_pkg::ST_OUT;
            apm_pkg::ST_OUT:   if (!r_ovalid || w_out_xfer) n_state = apm_pkg::ST_IDLE;
            default:           n_state = apm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= apm_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // mixing values
    logic signed [31:0] w_mix [4];
    logic signed [31:0] w_lim;
    always_comb begin
        w_lim = 32'($signed({1'b0, r_lim}));
        w_mix[0] = r_u[0] + r_u[2];
        w_mix[1] = -r_u[0] + r_u[2];
        w_mix[2] = r_u[1] - r_u[2];
        w_mix[3] = -r_u[1] - r_u[2];
    end

    // duty to compare
    function automatic logic [13:0] cmp_of(input logic signed [12:0] b,
                                           input logic signed [10:0] o);
        logic signed [14:0] d;
        d = 15'(b) + 15'(o);
        if (d < 15'sd500) d = 15'sd500;
        if (d > 15'sd1000) d = 15'sd1000;
        return 14'(15'sd10000 - d);
    endfunction

    logic signed [31:0] w_tsum, w_base;
    logic signed [63:0] w_acc_rnd;
    assign w_tsum = apm_pkg::sat16(32'(r_sum[r_ax]) + 32'(r_err));
    assign w_base = (32'sd3000 - 32'($signed({1'b0, i_throttle_raw}))) / 2;
    // bias negative values so the shift truncates toward zero
    assign w_acc_rnd = r_acc + (r_acc[63] ? 64'sd4294967295 : 64'sd0);

    // datapath and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= apm_pkg::GAIN_PROP_RST; r_ki <= apm_pkg::GAIN_INTEG_RST;
            for (int i = 0; i < 3; i++) begin
                r_lvl[i] <= '0; r_tgt[i] <= '0; r_last[i] <= '0;
                r_sum[i] <= '0; r_stk[i] <= '0;
            end
            for (int i = 0; i < 4; i++) r_off[i] <= '0;
            r_thr <= apm_pkg::MOVE_THR_RST; r_hold <= apm_pkg::HOLD_RST;
            r_lim <= apm_pkg::LIMIT_RST;
            r_dev <= '0; r_tick <= '0; r_base <= '0; r_kill <= 1'b0;
            r_ovalid <= 1'b0; r_wait <= '0; r_ax <= '0; r_upd <= 1'b0;
        end else begin
            if (w_out_xfer && r_state != apm_pkg::ST_OUT) r_ovalid <= 1'b0;
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    apm_pkg::REG_GAIN_PROP:  r_kp <= i_cfg_data[15:0];
                    apm_pkg::REG_GAIN_INTEG: r_ki <= i_cfg_data;
                    apm_pkg::REG_LVL_PITCH: begin
                        r_lvl[0] <= i_cfg_data[8:0]; r_last[0] <= 16'($signed(i_cfg_data[8:0]));
                    end
                    apm_pkg::REG_LVL_ROLL: begin
                        r_lvl[1] <= i_cfg_data[8:0]; r_last[1] <= 16'($signed(i_cfg_data[8:0]));
                    end
                    apm_pkg::REG_LVL_YAW: begin
                        r_lvl[2] <= i_cfg_data[8:0];
                        r_tgt[2] <= 16'($signed(i_cfg_data[8:0]));
                        r_last[2] <= 16'($signed(i_cfg_data[8:0]));
                    end
                    apm_pkg::REG_MOVE_THR: r_thr <= i_cfg_data[7:0];
                    apm_pkg::REG_HOLD:     r_hold <= i_cfg_data[15:0];
                    apm_pkg::REG_LIMIT:    r_lim <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                apm_pkg::ST_IDLE: if (w_in_xfer) begin
                    r_meas[0] <= i_meas_pitch; r_meas[1] <= i_meas_roll;
                    r_meas[2] <= i_meas_yaw;
                    if (i_packet_valid) begin
                        r_base <= (w_base > 32'sd4095) ? 13'sd4095 :
                                  (w_base < -32'sd4096) ? 13'(-32'sd4096) : 13'(w_base);
                        r_stk[0] <= 16'($signed({2'b0, i_fore_aft_raw}) - 16'sd1500);
                        r_stk[1] <= 16'($signed({2'b0, i_side_raw}) - 16'sd1500);
                        r_stk[2] <= 16'($signed({2'b0, i_turn_raw}) - 16'sd1500);
                        r_kill <= i_kill_switch;
                    end
                end
                apm_pkg::ST_PREP: begin
                    r_tgt[0] <= 16'(w_tp); r_tgt[1] <= 16'(w_tr);
                    if (r_tick + 1'b1 >= TW'(YAW_STEP_PERIODS)) begin
                        r_tick <= '0; r_tgt[2] <= 16'(w_ty);
                    end else r_tick <= r_tick + 1'b1;
                end
                apm_pkg::ST_CHECK: begin
                    r_ax <= '0; r_wait <= '0;
                    r_upd <= (n_state == apm_pkg::ST_MUL_P);
                    if (n_state == apm_pkg::ST_MUL_P) begin
                        r_dev <= '0;
                        for (int i = 0; i < 3; i++) r_last[i] <= 16'(r_meas[i]);
                        r_tgt[2] <= 16'(w_unw);
                    end else if (w_off_t && r_dev != 16'hFFFF) r_dev <= r_dev + 1'b1;
                end
                apm_pkg::ST_MUL_P: begin
                    if (r_wait == 2'd0) r_err <= 16'(w_e);
                    r_wait <= r_wait + 1'b1;
                    if (r_wait == 2'd3) r_acc <= 64'(w_prod) <<< 24;
                end
                apm_pkg::ST_MUL_I: begin
                    if (r_wait == 2'd0) r_sum[r_ax] <= 16'(w_tsum);
                    r_wait <= r_wait + 1'b1;
                    if (r_wait == 2'd3) r_m <= 41'(w_prod / 256);
                end
                apm_pkg::ST_MUL_M: begin
                    r_wait <= r_wait + 1'b1;
                    if (r_wait == 2'd3) r_acc <= r_acc + 64'(w_prod);
                end
                apm_pkg::ST_ACC: begin
                    r_u[r_ax] <= 32'(w_acc_rnd >>> 32);
                    r_ax <= (r_ax == 2'd2) ? 2'd0 : r_ax + 1'b1;
                end
                apm_pkg::ST_MIX: begin
                    for (int i = 0; i < 4; i++)
                        r_off[i] <= (w_mix[i] > w_lim) ? 11'(w_lim) :
                                    (w_mix[i] < -w_lim) ? 11'(-w_lim) : 11'(w_mix[i]);
                end
                apm_pkg::ST_OUT: if (!r_ovalid || w_out_xfer) begin
                    r_ovalid <= 1'b1;
                    if (r_kill) begin
                        r_base <= 13'sd500;
                        for (int i = 0; i < 4; i++) r_off[i] <= '0;
                    end
                    o_cmp_front <= cmp_of(r_kill ? 13'sd500 : r_base, r_kill ? 11'sd0 : r_off[0]);
                    o_cmp_back  <= cmp_of(r_kill ? 13'sd500 : r_base, r_kill ? 11'sd0 : r_off[1]);
                    o_cmp_left  <= cmp_of(r_kill ? 13'sd500 : r_base, r_kill ? 11'sd0 : r_off[2]);
                    o_cmp_right <= cmp_of(r_kill ? 13'sd500 : r_base, r_kill ? 11'sd0 : r_off[3]);
                    o_loop_updated <= r_upd;
                end
                default: ;
            endcase
        end
    end

    `include "attitude_pid_motor_mixer_assert.svh"
    `APM_ASSERT(a_no_accept_busy, (r_state != apm_pkg::ST_IDLE) |-> o_stall, "accept while busy")
    `APM_ASSERT(a_out_held, (o_valid && i_stall) |=> o_valid, "result dropped under stall")
    `APM_ASSERT(a_axis_range, r_ax != 2'd3, "axis index out of range")
    `APM_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> (r_state == apm_pkg::ST_IDLE), "not idle after reset")
endmodule
